// File: design/okvt_pkg.sv
// okvt_pkg: shared types and constants for the ordered key/value table
// word layouts for the request and response channels, cell control and chain links
// no dependencies
`timescale 1ns / 1ps

package okvt_pkg;

    localparam int KEY_BITS       = 8;
    localparam int VALUE_BITS     = 32;
    localparam int POS_BITS       = 4;
    localparam int COUNT_OUT_BITS = 5;

    typedef enum logic [1:0] {
        CMD_WRITE    = 2'd0,
        CMD_ERASE    = 2'd1,
        CMD_READ_KEY = 2'd2,
        CMD_READ_POS = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CELL_IDLE,
        CELL_LOOK,
        CELL_UPDATE,
        CELL_INSERT,
        CELL_ERASE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC
    } tbl_state_t;

    typedef struct packed {
        cmd_t                          cmd;
        logic [KEY_BITS-1:0]           key;
        logic signed [VALUE_BITS-1:0]  data_in;
        logic [POS_BITS-1:0]           position;
        logic                          may_insert;
        logic                          may_update;
    } req_word_t;

    typedef struct packed {
        logic                          ok;
        logic [KEY_BITS-1:0]           key_out;
        logic signed [VALUE_BITS-1:0]  data_out;
        logic [COUNT_OUT_BITS-1:0]     entry_count;
        logic                          full_reject;
    } rsp_word_t;

    // broadcast to every cell
    typedef struct packed {
        cell_op_t                op;
        logic                    by_pos;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
        logic [POS_BITS-1:0]     position;
    } cell_ctl_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
    } entry_t;

    // runs from cell 0 upward: prefix of hits and the or of the hit entry
    typedef struct packed {
        logic                    seen;
        logic [KEY_BITS-1:0]     key;
        logic [VALUE_BITS-1:0]   value;
    } scan_t;

endpackage

// File: design/okvt_cell.sv
// okvt_cell: one slot of the table, holding a key/value pair and a hit flag
// shifts down from its upper neighbor on erase; depends on okvt_pkg
`timescale 1ns / 1ps

module okvt_cell #(
    parameter int CELL_INDEX = 0,
    parameter int CNT_W      = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  okvt_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]    count,
    input  okvt_pkg::entry_t    upper,
    output okvt_pkg::entry_t    entry,
    input  okvt_pkg::scan_t     scan_in,
    output okvt_pkg::scan_t     scan_out,
    output logic                hit
);
    import okvt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit_reg;
    logic   hit_next;
    logic   occupied;
    logic   at_tail;
    logic   shift_down;

    assign occupied   = CELL_INDEX < int'(count);
    assign at_tail    = CELL_INDEX == int'(count);
    assign shift_down = scan_in.seen | hit_reg;

    always_comb
    begin
        hit_next = hit_reg;
        case (ctl.op)
            CELL_LOOK:
            begin
                if (ctl.by_pos)
                begin
                    hit_next = occupied && (int'(ctl.position) == CELL_INDEX);
                end
                else
                begin
                    hit_next = occupied && (ctl.key == entry_reg.key);
                end
            end
            default:
            begin
                hit_next = hit_reg;
            end
        endcase
    end

    always_comb
    begin
        entry_next = entry_reg;
        case (ctl.op)
            CELL_UPDATE:
            begin
                if (hit_reg)
                begin
                    entry_next.value = ctl.value;
                end
            end
            CELL_INSERT:
            begin
                if (at_tail)
                begin
                    entry_next.key   = ctl.key;
                    entry_next.value = ctl.value;
                end
            end
            CELL_ERASE:
            begin
                // every slot at or past the erased one takes its upper neighbor
                if (shift_down)
                begin
                    entry_next = upper;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry          = entry_reg;
    assign hit            = hit_reg;
    assign scan_out.seen  = shift_down;
    assign scan_out.key   = scan_in.key | (hit_reg ? entry_reg.key : '0);
    assign scan_out.value = scan_in.value | (hit_reg ? entry_reg.value : '0);

endmodule

// File: design/ordered_key_value_table.sv
// ordered_key_value_table: insertion-ordered key/value map built from a row of cells
// a taken request word is registered, compared in the cells in the look state, then applied
// in exec, which registers its response; a request is taken only when idle or as exec ends
// the response register lets the next request in while a response waits
// reset: entry count, hit flags and handshake state clear; slot contents stay unknown
// depends on okvt_pkg and okvt_cell
`timescale 1ns / 1ps

module ordered_key_value_table #(
    parameter int ENTRIES = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  okvt_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output okvt_pkg::rsp_word_t rsp
);
    import okvt_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    tbl_state_t        state_reg;
    tbl_state_t        state_next;
    req_word_t         req_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    rsp_word_t         rsp_reg;
    rsp_word_t         rsp_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    logic              advance;
    logic              accept;
    logic              found;
    logic              full;
    cell_ctl_t         ctl;

    scan_t             scan [0:ENTRIES];
    entry_t            ent  [0:ENTRIES];
    logic [ENTRIES-1:0] hit_vec;

    assign advance   = (state_reg == ST_EXEC) && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = !((state_reg == ST_IDLE) || advance);
    assign accept    = req_valid && !req_stall;
    assign found     = scan[ENTRIES].seen;
    assign full      = count_reg == CNT_W'(ENTRIES);

    assign scan[0]      = '0;
    assign ent[ENTRIES] = '0;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        okvt_cell #(
            .CELL_INDEX (i),
            .CNT_W      (CNT_W)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (ctl),
            .count    (count_reg),
            .upper    (ent[i+1]),
            .entry    (ent[i]),
            .scan_in  (scan[i]),
            .scan_out (scan[i+1]),
            .hit      (hit_vec[i])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                state_next = accept ? ST_LOOK : ST_IDLE;
            end
            ST_LOOK:
            begin
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (advance)
                begin
                    state_next = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // cell control, count and response
    always_comb
    begin
        ctl.op       = CELL_IDLE;
        ctl.by_pos   = req_reg.cmd == CMD_READ_POS;
        ctl.key      = req_reg.key;
        ctl.value    = req_reg.data_in;
        ctl.position = req_reg.position;
        count_next   = count_reg;
        rsp_next     = rsp_reg;
        case (state_reg)
            ST_LOOK:
            begin
                ctl.op = CELL_LOOK;
            end
            ST_EXEC:
            begin
                if (advance)
                begin
                    rsp_next = '0;
                    case (req_reg.cmd)
                        CMD_WRITE:
                        begin
                            if (found)
                            begin
                                if (req_reg.may_update)
                                begin
                                    ctl.op      = CELL_UPDATE;
                                    rsp_next.ok = 1'b1;
                                end
                            end
                            else if (req_reg.may_insert)
                            begin
                                if (full)
                                begin
                                    rsp_next.full_reject = 1'b1;
                                end
                                else
                                begin
                                    ctl.op      = CELL_INSERT;
                                    count_next  = count_reg + CNT_W'(1);
                                    rsp_next.ok = 1'b1;
                                end
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (found)
                            begin
                                ctl.op      = CELL_ERASE;
                                count_next  = count_reg - CNT_W'(1);
                                rsp_next.ok = 1'b1;
                            end
                        end
                        CMD_READ_KEY:
                        begin
                            rsp_next.ok       = found;
                            rsp_next.data_out = $signed(scan[ENTRIES].value);
                        end
                        CMD_READ_POS:
                        begin
                            rsp_next.ok       = found;
                            rsp_next.key_out  = scan[ENTRIES].key;
                            rsp_next.data_out = $signed(scan[ENTRIES].value);
                        end
                        default:
                        begin
                            rsp_next.ok = 1'b0;
                        end
                    endcase
                    rsp_next.entry_count = COUNT_OUT_BITS'(count_next);
                end
            end
            default:
            begin
                ctl.op = CELL_IDLE;
            end
        endcase
        rsp_valid_next = advance || (rsp_valid_reg && rsp_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // keys are unique and positions distinct, so no two cells can hit at once
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(hit_vec))
        else $error("more than one cell hit");

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    // a waiting response always reflects the current count
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.entry_count == COUNT_OUT_BITS'(count_reg))
        else $error("response count out of step with table");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == ST_EXEC))
        else $error("response without an update cycle");

endmodule
